/* rtl/core/lsp_filt_pkg.sv */
`timescale 1ns / 1ps

package lsp_filt_pkg;

    localparam int MAX_SECTIONS = 16;
    localparam int IDX_W        = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
    localparam int CNT_W        = $clog2(MAX_SECTIONS + 1);

    localparam int COEF_W       = 16;
    localparam int SAMPLE_W     = 16;
    localparam int STATE_W      = 32;
    localparam int PROD_W       = COEF_W + STATE_W;
    localparam int COEF_FRAC    = 14;
    localparam int SUM_W        = 36;
    localparam int CFG_W        = 5;
    localparam int COUNT_RESET  = 10;

    localparam logic signed [PROD_W-1:0] ROUND_BIAS = PROD_W'(1 << (COEF_FRAC - 1));
    localparam logic signed [SUM_W-1:0]  SAT_MAX    = SUM_W'(64'sd2147483647);
    localparam logic signed [SUM_W-1:0]  SAT_MIN    = -SUM_W'(64'sd2147483648);

    localparam logic KIND_FILTER = 1'b0;
    localparam logic KIND_LOAD   = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_D1,
        ST_MUL_A,
        ST_UPDATE,
        ST_OUTPUT
    } seq_state_t;

    function automatic logic signed [STATE_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
        logic signed [STATE_W-1:0] r;
        if (v > SAT_MAX) begin
            r = SAT_MAX[STATE_W-1:0];
        end else if (v < SAT_MIN) begin
            r = SAT_MIN[STATE_W-1:0];
        end else begin
            r = v[STATE_W-1:0];
        end
        return r;
    endfunction

endpackage

/* rtl/core/lsp_structure_filter_step.sv */
`timescale 1ns / 1ps
// line spectral pair structured filter, one sample per transaction
// input channel (s_*): kind 0 runs s_sample through the section cascade and
//   gives one m_filter_out transaction; kind 1 writes s_coef_value into the
//   coefficient of section s_coef_index and gives nothing
// config channel (cfg_*): sets the section count n (reset 10), odd or even
//   picks the output rule; counts above the table size use the table size
// one shared 16 x 32 multiplier does both products of a section, so each
//   section passes through ST_MUL_D1, ST_MUL_A and ST_UPDATE: a sample transaction
//   reaches m_valid after its sections and ST_OUTPUT, s_ready rises in that same
//   cycle, and no new sample is taken until the last one's result is written
// a coefficient load leaves the sequencer idle; s_ready stays high through it
// results sit in an output register; a stalled receiver holds the finished
//   result there and the sequencer waits before writing the next one
// reset clears coefficients, delay words, tail word and the output valid
module lsp_structure_filter_step (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [lsp_filt_pkg::CFG_W-1:0]         cfg_data,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic                                   s_kind,
    input  logic signed [lsp_filt_pkg::SAMPLE_W-1:0] s_sample,
    input  logic [3:0]                             s_coef_index,
    input  logic signed [lsp_filt_pkg::COEF_W-1:0] s_coef_value,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [lsp_filt_pkg::STATE_W-1:0] m_filter_out
);
    import lsp_filt_pkg::*;

    seq_state_t state_reg, state_next;

    logic [CFG_W-1:0]          section_count_reg;
    logic [IDX_W-1:0]          sec_reg, sec_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic [CNT_W-1:0]          count_clamped;

    logic signed [COEF_W-1:0]  coef_mem [MAX_SECTIONS];
    logic signed [STATE_W-1:0] d1_mem   [MAX_SECTIONS];
    logic signed [STATE_W-1:0] d2_mem   [MAX_SECTIONS];

    logic signed [STATE_W-1:0] a_reg [2];
    logic signed [STATE_W-1:0] b_reg [2];
    logic signed [STATE_W-1:0] tail_reg, tail_next;
    logic signed [STATE_W-1:0] t_reg, t_next;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic signed [STATE_W-1:0] result_reg, result_next;
    logic                      m_valid_reg, m_valid_next;

    logic                      chain;
    logic signed [COEF_W-1:0]  coef_cur;
    logic signed [STATE_W-1:0] d1_cur, d2_cur, a_cur, b_cur, b_new;
    logic signed [STATE_W-1:0] mul_x;
    logic signed [SUM_W-1:0]   mul_term, out_sum;
    logic signed [STATE_W-1:0] x_in;
    logic                      in_accept, load_en, start_en, update_en;
    logic                      last_sec;

    assign cfg_ready    = 1'b1;
    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_filter_out = result_reg;

    assign in_accept = s_valid && s_ready;
    assign load_en   = in_accept && (s_kind == KIND_LOAD) && (32'(s_coef_index) < MAX_SECTIONS);
    assign start_en  = in_accept && (s_kind == KIND_FILTER);
    assign update_en = (state_reg == ST_UPDATE);

    assign x_in = {s_sample, 16'h0000};

    assign count_clamped = (32'(section_count_reg) > MAX_SECTIONS) ?
                           CNT_W'(MAX_SECTIONS) : CNT_W'(section_count_reg);

    assign chain    = sec_reg[0];
    assign coef_cur = coef_mem[sec_reg];
    assign d1_cur   = d1_mem[sec_reg];
    assign d2_cur   = d2_mem[sec_reg];
    assign a_cur    = a_reg[chain];
    assign b_cur    = b_reg[chain];
    assign last_sec = (CNT_W'(sec_reg) + CNT_W'(1)) == count_reg;

    // shared multiplier, rounding bias folded in
    assign mul_x     = (state_reg == ST_MUL_D1) ? d1_cur : a_cur;
    assign prod_next = PROD_W'(coef_cur) * PROD_W'(mul_x) + ROUND_BIAS;
    assign mul_term  = SUM_W'($signed(prod_reg[PROD_W-1:COEF_FRAC]));

    assign b_new = sat32(SUM_W'(b_cur) + mul_term + SUM_W'(d1_cur));

    always_comb begin
        state_next   = state_reg;
        sec_next     = sec_reg;
        count_next   = count_reg;
        t_next       = t_reg;
        tail_next    = tail_reg;
        result_next  = result_reg;
        m_valid_next = m_valid_reg && !m_ready;
        out_sum      = '0;
        case (state_reg)
            ST_IDLE: begin
                if (start_en) begin
                    sec_next   = '0;
                    count_next = count_clamped;
                    state_next = (count_clamped == '0) ? ST_OUTPUT : ST_MUL_D1;
                end
            end
            ST_MUL_D1: begin
                state_next = ST_MUL_A;
            end
            ST_MUL_A: begin
                t_next     = sat32(SUM_W'(a_cur) + mul_term + SUM_W'(d2_cur));
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                sec_next   = sec_reg + IDX_W'(1);
                state_next = last_sec ? ST_OUTPUT : ST_MUL_D1;
            end
            ST_OUTPUT: begin
                if (count_reg[0]) begin
                    out_sum = SUM_W'(b_reg[0]) + SUM_W'(b_reg[1]) - SUM_W'(tail_reg)
                              + SUM_W'(1);
                end else begin
                    out_sum = SUM_W'(a_reg[0]) - SUM_W'(a_reg[1]) + SUM_W'(b_reg[0])
                              + SUM_W'(b_reg[1]) + SUM_W'(1);
                end
                if (!m_valid_reg || m_ready) begin
                    result_next  = sat32(out_sum >>> 1);
                    m_valid_next = 1'b1;
                    if (count_reg[0]) begin
                        tail_next = a_reg[1];
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            section_count_reg <= CFG_W'(COUNT_RESET);
            m_valid_reg       <= 1'b0;
            tail_reg          <= '0;
            sec_reg           <= '0;
            count_reg         <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            tail_reg    <= tail_next;
            sec_reg     <= sec_next;
            count_reg   <= count_next;
            if (cfg_valid && cfg_ready) begin
                section_count_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        t_reg      <= t_next;
        result_reg <= result_next;
        if (state_reg == ST_MUL_D1 || state_reg == ST_MUL_A) begin
            prod_reg <= prod_next;
        end
        if (start_en) begin
            a_reg[0] <= x_in;
            a_reg[1] <= x_in;
            b_reg[0] <= '0;
            b_reg[1] <= '0;
        end else if (update_en) begin
            a_reg[chain] <= t_reg;
            b_reg[chain] <= b_new;
        end
    end

    // section table, cleared at reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < MAX_SECTIONS; k++) begin
                coef_mem[k] <= '0;
                d1_mem[k]   <= '0;
                d2_mem[k]   <= '0;
            end
        end else begin
            if (load_en) begin
                coef_mem[IDX_W'(s_coef_index)] <= s_coef_value;
            end
            if (update_en) begin
                d2_mem[sec_reg] <= d1_cur;
                d1_mem[sec_reg] <= a_cur;
            end
        end
    end

    a_count_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> (32'(count_reg) <= MAX_SECTIONS))
        else $error("section count beyond table");

    a_sec_below_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MUL_D1 || state_reg == ST_MUL_A || state_reg == ST_UPDATE)
        |-> (CNT_W'(sec_reg) < count_reg))
        else $error("section index past count");

    a_load_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && s_kind == KIND_LOAD && !m_valid_reg) |=> !m_valid_reg)
        else $error("coefficient load produced a result");

    a_sample_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        start_en |=> (state_reg != ST_IDLE))
        else $error("sample transaction did not start the sequencer");

endmodule

/* verif/lsp_structure_filter_step_tb.sv */
`timescale 1ns / 1ps

module lsp_structure_filter_step_tb;
    import lsp_filt_pkg::*;

    typedef struct {
        logic                       kind;
        logic signed [SAMPLE_W-1:0] sample;
        logic [3:0]                 coef_index;
        logic signed [COEF_W-1:0]   coef_value;
    } filter_req_t;

    logic                        aclk = 1'b0;
    logic                        aresetn = 1'b0;
    logic                        cfg_valid = 1'b0;
    logic                        cfg_ready;
    logic [CFG_W-1:0]            cfg_data = '0;
    logic                        s_valid = 1'b0;
    logic                        s_ready;
    logic                        s_kind = KIND_FILTER;
    logic signed [SAMPLE_W-1:0]  s_sample = '0;
    logic [3:0]                  s_coef_index = '0;
    logic signed [COEF_W-1:0]    s_coef_value = '0;
    logic                        m_valid;
    logic                        m_ready = 1'b0;
    logic signed [STATE_W-1:0]   m_filter_out;

    filter_req_t                 filter_requests[$];
    int                          expected_filter_out[$];
    filter_req_t                 next_req;

    // filter state mirror
    logic signed [COEF_W-1:0]    coef_model [MAX_SECTIONS];
    int                          first_delay_model [MAX_SECTIONS];
    int                          second_delay_model [MAX_SECTIONS];
    int                          tail_model;
    logic [CFG_W-1:0]            section_count_model;

    bit                          s_taken = 1'b0;
    bit                          m_taken = 1'b0;
    bit                          send_idle = 1'b0;
    bit                          recv_idle = 1'b0;
    int                          send_wait = 0;
    int                          recv_wait = 0;
    int                          long_hold = 0;
    int                          errors = 0;
    int                          want;

    lsp_structure_filter_step dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_kind       (s_kind),
        .s_sample     (s_sample),
        .s_coef_index (s_coef_index),
        .s_coef_value (s_coef_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_filter_out (m_filter_out)
    );

    always #10 aclk = ~aclk;

    function automatic int saturate_q16(input longint v);
        if (v > longint'(32'sh7fffffff)) begin
            return 32'sh7fffffff;
        end else if (v < -longint'(64'sd2147483648)) begin
            return 32'sh80000000;
        end
        return int'(v);
    endfunction

    // coefficient times state word, rounded back to 16 fraction bits
    function automatic longint coef_product(input longint c, input longint x);
        return (c * x + 64'sd8192) >>> 14;
    endfunction

    function automatic int step_cascade(input logic signed [SAMPLE_W-1:0] smp);
        longint a [2];
        longint b [2];
        longint c, d1, d2, t, acc;
        int n, p, res;
        a[0] = longint'(smp) * 65536;
        a[1] = a[0];
        b[0] = 0;
        b[1] = 0;
        n = (int'(section_count_model) > MAX_SECTIONS) ? MAX_SECTIONS
                                                       : int'(section_count_model);
        for (int i = 0; i < n; i++) begin
            p  = i & 1;
            c  = coef_model[i];
            d1 = first_delay_model[i];
            d2 = second_delay_model[i];
            t  = saturate_q16(a[p] + coef_product(c, d1) + d2);
            b[p] = saturate_q16(b[p] + coef_product(c, a[p]) + d1);
            second_delay_model[i] = int'(d1);
            first_delay_model[i]  = int'(a[p]);
            a[p] = t;
        end
        if (n % 2 == 1) begin
            acc = b[0] + b[1] - longint'(tail_model);
            res = saturate_q16((acc + 1) >>> 1);
            tail_model = int'(a[1]);
        end else begin
            acc = a[0] - a[1] + b[0] + b[1];
            res = saturate_q16((acc + 1) >>> 1);
        end
        return res;
    endfunction

    function automatic filter_req_t random_req(input int coef_span);
        filter_req_t r;
        int pick;
        r.kind = ($urandom_range(0, 3) == 0) ? KIND_LOAD : KIND_FILTER;
        r.coef_index = 4'($urandom_range(0, 15));
        pick = $urandom_range(0, 7);
        if (pick == 0) begin
            r.coef_value = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
        end else if (pick == 1) begin
            r.coef_value = 16'($urandom);
        end else begin
            r.coef_value = 16'($urandom_range(0, 2 * coef_span) - coef_span);
        end
        pick = $urandom_range(0, 7);
        if (pick == 0) begin
            r.sample = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
        end else if (pick < 3) begin
            r.sample = 16'($urandom_range(0, 255) - 128);
        end else begin
            r.sample = 16'($urandom);
        end
        return r;
    endfunction

    task automatic push_load(input int idx, input int value);
        filter_req_t r;
        r.kind = KIND_LOAD;
        r.sample = '0;
        r.coef_index = 4'(idx);
        r.coef_value = 16'(value);
        filter_requests.push_back(r);
    endtask

    task automatic push_sample(input int value);
        filter_req_t r;
        r.kind = KIND_FILTER;
        r.sample = 16'(value);
        r.coef_index = '0;
        r.coef_value = '0;
        filter_requests.push_back(r);
    endtask

    task automatic wait_quiet();
        while (filter_requests.size() != 0 || s_valid || expected_filter_out.size() != 0) begin
            @(posedge aclk);
        end
        // leave room for the longest sample, with every table section in use
        repeat (60) @(posedge aclk);
    endtask

    task automatic set_section_count(input logic [CFG_W-1:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
        section_count_model = value;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] count, input int n_items,
                             input int coef_span, input bit idle, input int hold);
        set_section_count(count);
        send_idle = idle;
        recv_idle = idle;
        long_hold = hold;
        repeat (n_items) filter_requests.push_back(random_req(coef_span));
        wait_quiet();
    endtask

    // transaction monitor and predictor
    always @(posedge aclk) begin
        s_taken = aresetn && s_valid && s_ready;
        m_taken = aresetn && m_valid && m_ready;
        if (m_taken) begin
            if (expected_filter_out.size() == 0) begin
                errors++;
                $display("%0t: unexpected filter_out %0d", $time, m_filter_out);
            end else begin
                want = expected_filter_out.pop_front();
                if (m_filter_out !== want) begin
                    errors++;
                    $display("%0t: filter_out expected %0d actual %0d",
                             $time, want, m_filter_out);
                end
            end
        end
        if (s_taken) begin
            if (s_kind == KIND_LOAD) begin
                coef_model[s_coef_index] = s_coef_value;
            end else begin
                expected_filter_out.push_back(step_cascade(s_sample));
            end
        end
    end

    // sender
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_taken) begin
            if (send_wait > 0) begin
                send_wait--;
                s_valid <= 1'b0;
            end else if (filter_requests.size() != 0) begin
                next_req = filter_requests.pop_front();
                s_valid      <= 1'b1;
                s_kind       <= next_req.kind;
                s_sample     <= next_req.sample;
                s_coef_index <= next_req.coef_index;
                s_coef_value <= next_req.coef_value;
                send_wait = send_idle ? $urandom_range(0, 8) : 0;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_taken) begin
                recv_wait = recv_idle ? $urandom_range(0, 8) : 0;
            end
            if (long_hold > 0) begin
                long_hold--;
                m_ready <= 1'b0;
            end else if (recv_wait > 0) begin
                recv_wait--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        for (int i = 0; i < MAX_SECTIONS; i++) begin
            coef_model[i] = '0;
            first_delay_model[i] = 0;
            second_delay_model[i] = 0;
        end
        tail_model = 0;
        section_count_model = CFG_W'(COUNT_RESET);

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // reset count, table extremes, sample extremes
        push_sample(32767);
        push_load(0, 32767);
        push_load(1, -32768);
        push_load(2, 16384);
        push_load(3, -16384);
        push_load(4, 1);
        push_load(9, -1);
        push_sample(32767);
        push_sample(-32768);
        push_sample(0);
        push_sample(1);
        push_sample(-1);
        push_load(15, -32768);
        push_load(8, 32767);
        push_sample(-32768);
        push_sample(100);
        push_load(0, 0);
        push_load(1, 0);
        push_sample(32767);
        push_sample(-200);
        wait_quiet();

        // zero sections
        run_phase(5'd0, 8, 32767, 1'b1, 0);
        // above table size
        run_phase(5'd31, 60, 8192, 1'b1, 0);
        run_phase(5'd1, 60, 32767, 1'b1, 0);
        // receiver holds off, block fills up
        run_phase(5'd16, 60, 16384, 1'b0, 400);
        run_phase(5'd2, 50, 4096, 1'b1, 0);
        run_phase(5'd15, 60, 16384, 1'b1, 0);
        run_phase(5'd7, 50, 32767, 1'b0, 0);
        run_phase(5'd10, 60, 8192, 1'b1, 0);

        if (errors == 0 && expected_filter_out.size() == 0) begin
            $display("lsp_structure_filter_step_tb passed");
        end else begin
            $display("lsp_structure_filter_step_tb failed");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("lsp_structure_filter_step_tb failed");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/lsp_filt_pkg.sv
rtl/core/lsp_structure_filter_step.sv
verif/lsp_structure_filter_step_tb.sv
